// ===== hdl/misd_pkg.sv =====
// ----------------------------------------------------------------------------
// misd_pkg: shared types and constants of the scan debouncer
// Holds the per-channel state record, the register index codes and the
// fixed field widths that the channel slice and the top level both use.
// ----------------------------------------------------------------------------
package misd_pkg;

   // Field widths fixed by the stream and register formats
   localparam int PIN_W      = 8;
   localparam int SELECT_W   = 2;
   localparam int STATES_W   = 32;
   localparam int COUNT_W    = 4;
   localparam int TIMER_W    = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int RSP_DATA_W  = 48;

   // Register index codes
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES_NEEDED = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCKOUT_TIME   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK_PERIOD    = 2'd2;

   // Register reset values
   localparam logic [COUNT_W-1:0] SAMPLES_NEEDED_RST = 4'd3;
   localparam logic [TIMER_W-1:0] LOCKOUT_TIME_RST   = 8'd20;
   localparam logic [TIMER_W-1:0] TICK_PERIOD_RST    = 8'd1;

   // Per-channel state: cnt_one counts samples at level 1, cnt_zero at level 0
   typedef struct packed {
      logic               debounced;
      logic [COUNT_W-1:0] cnt_zero;
      logic [COUNT_W-1:0] cnt_one;
      logic [TIMER_W-1:0] timer;
   } chan_state_type;

   // Settings shared by every channel slice
   typedef struct packed {
      logic [COUNT_W-1:0] samples_needed;
      logic [TIMER_W-1:0] lockout_time;
      logic [TIMER_W-1:0] tick_period;
   } chan_cfg_type;

endpackage

// ===== hdl/misd_channel.sv =====
// ----------------------------------------------------------------------------
// misd_channel: next-state logic of one debounced channel
// Runs the lockout timer down, or counts consecutive differing samples and
// flips the debounced state once the required run is reached.
// ----------------------------------------------------------------------------
module misd_channel (
   input  logic                    level,
   input  misd_pkg::chan_cfg_type  cfg,
   input  misd_pkg::chan_state_type cur,
   output misd_pkg::chan_state_type nxt,
   output logic                    flip
);

   logic [misd_pkg::COUNT_W-1:0] run_cnt;
   logic [misd_pkg::COUNT_W-1:0] run_new;

   // Pick the run counter of the sampled level and advance it below the limit
   always_comb begin
      run_cnt = level ? cur.cnt_one : cur.cnt_zero;
      run_new = (run_cnt < cfg.samples_needed) ? run_cnt + 4'd1 : run_cnt;
   end

   // Lockout countdown, otherwise run counting and state flip
   always_comb begin
      nxt  = cur;
      flip = 1'b0;
      if (cur.timer != '0) begin
         nxt.timer = (cur.timer > cfg.tick_period) ? cur.timer - cfg.tick_period : '0;
      end else begin
         if (level) begin
            nxt.cnt_zero = '0;
         end else begin
            nxt.cnt_one = '0;
         end
         if (level != cur.debounced) begin
            if (level) begin
               nxt.cnt_one = run_new;
            end else begin
               nxt.cnt_zero = run_new;
            end
            if (run_new == cfg.samples_needed) begin
               nxt.debounced = level;
               nxt.timer     = cfg.lockout_time;
               flip          = 1'b1;
            end
         end
      end
   end

endmodule

// ===== hdl/muxed_input_scan_debouncer.sv =====
// ----------------------------------------------------------------------------
// muxed_input_scan_debouncer: debouncer for pins shared by multiplexed groups
// Debounces the pins of the selected group on each scan tick, with lockout.
// ----------------------------------------------------------------------------
// One scan tick is taken per clock cycle without gaps while the input is not
// stalled: the tick is held in an input register, all channels of the selected
// group are updated in parallel from it, and the result register, loaded with
// that update, presents the new select value, the 32 lowest debounced states
// and the flip mask. A tick's result thus passes the input register and then
// the result register before it leaves. A waiting result holds the input
// register, and the input stalls only while both registers are full and
// rsp_tready is low. The per-channel state sits in flip-flop rows, one row per
// group, cleared by reset. The user must see that configuration is written
// through the csr_ port only while no tick is in flight; the block does not enforce it.
module muxed_input_scan_debouncer #(
   parameter int PIN_COUNT   = 8,
   parameter int SELECT_BITS = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration writes
   input  logic                                csr_wr_en,
   input  logic [misd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [misd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // Scan ticks
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [misd_pkg::PIN_W-1:0]          req_tdata,  // [7:0] pin_levels
   // Results
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [1:0] select_lines, [33:2] debounced_states, [41:34] changed_mask, rest zero
   output logic [misd_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int GROUPS   = 1 << SELECT_BITS;
   localparam int GROUP_W  = (SELECT_BITS > 0) ? SELECT_BITS : 1;
   localparam int CHANNELS = PIN_COUNT * GROUPS;
   localparam int FLAT_W   = (CHANNELS > misd_pkg::STATES_W) ? CHANNELS : misd_pkg::STATES_W;
   localparam logic [GROUP_W-1:0] GROUP_MASK = GROUP_W'(GROUPS - 1);

   // Configuration registers
   misd_pkg::chan_cfg_type cfg_ff;

   // Pipeline registers
   logic                            in_valid_ff;
   logic [misd_pkg::PIN_W-1:0]      pins_ff;
   logic                            out_valid_ff;
   logic [misd_pkg::SELECT_W-1:0]   sel_ff;
   logic [misd_pkg::STATES_W-1:0]   states_ff;
   logic [misd_pkg::PIN_W-1:0]      changed_ff;

   // Scan state
   logic [GROUP_W-1:0]              group_ff;
   logic [GROUP_W-1:0]              group_in;
   logic [misd_pkg::COUNT_W-1:0]    sample_cnt_ff;
   logic [misd_pkg::COUNT_W-1:0]    sample_cnt_in;
   misd_pkg::chan_state_type        chan_ff [GROUPS][PIN_COUNT];

   // Working signals
   logic                            advance;
   logic                            compute;
   misd_pkg::chan_state_type        row_cur [PIN_COUNT];
   misd_pkg::chan_state_type        row_new [PIN_COUNT];
   logic [PIN_COUNT-1:0]            flip;
   logic [misd_pkg::PIN_W-1:0]      changed_in;
   logic [FLAT_W-1:0]               flat_states;
   logic [31:0]                     group_wide;

   // Handshake: a tick moves on when the result register is free or drains
   assign advance    = !out_valid_ff || rsp_tready;
   assign compute    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.samples_needed <= misd_pkg::SAMPLES_NEEDED_RST;
         cfg_ff.lockout_time   <= misd_pkg::LOCKOUT_TIME_RST;
         cfg_ff.tick_period    <= misd_pkg::TICK_PERIOD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            misd_pkg::CSR_SAMPLES_NEEDED: cfg_ff.samples_needed <= csr_wdata[3:0];
            misd_pkg::CSR_LOCKOUT_TIME:   cfg_ff.lockout_time   <= csr_wdata;
            misd_pkg::CSR_TICK_PERIOD:    cfg_ff.tick_period    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Channel slices of the selected group
   for (genvar p = 0; p < PIN_COUNT; p++) begin : g_chan
      logic level;
      if (p < misd_pkg::PIN_W) begin : g_pin
         assign level = pins_ff[p];
      end else begin : g_nopin
         assign level = 1'b0;
      end
      assign row_cur[p] = chan_ff[group_ff][p];
      misd_channel u_channel (
         .level (level),
         .cfg   (cfg_ff),
         .cur   (row_cur[p]),
         .nxt   (row_new[p]),
         .flip  (flip[p])
      );
   end

   // Flip mask of the low eight pins
   always_comb begin
      changed_in = '0;
      for (int p = 0; p < PIN_COUNT && p < misd_pkg::PIN_W; p++) begin
         changed_in[p] = flip[p];
      end
   end

   // Group sequencing: advance after samples_needed ticks
   always_comb begin
      sample_cnt_in = sample_cnt_ff + 4'd1;
      group_in      = group_ff;
      if (sample_cnt_in >= cfg_ff.samples_needed) begin
         sample_cnt_in = '0;
         group_in      = (group_ff + 1'b1) & GROUP_MASK;
      end
   end

   // Debounced states after this tick, selected row replaced by its update
   always_comb begin
      flat_states = '0;
      for (int g = 0; g < GROUPS; g++) begin
         for (int p = 0; p < PIN_COUNT; p++) begin
            if (GROUP_W'(g) == group_ff) begin
               flat_states[g*PIN_COUNT+p] = row_new[p].debounced;
            end else begin
               flat_states[g*PIN_COUNT+p] = chan_ff[g][p].debounced;
            end
         end
      end
   end

   assign group_wide = 32'(group_in);

   // Input register: hold a tick until it is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         pins_ff <= req_tdata;
      end
   end

   // Scan state update on each processed tick
   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff      <= '0;
         sample_cnt_ff <= '0;
         for (int g = 0; g < GROUPS; g++) begin
            for (int p = 0; p < PIN_COUNT; p++) begin
               chan_ff[g][p] <= '0;
            end
         end
      end else if (compute) begin
         group_ff      <= group_in;
         sample_cnt_ff <= sample_cnt_in;
         for (int g = 0; g < GROUPS; g++) begin
            if (GROUP_W'(g) == group_ff) begin
               for (int p = 0; p < PIN_COUNT; p++) begin
                  chan_ff[g][p] <= row_new[p];
               end
            end
         end
      end
   end

   // Result register: load on compute, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
      if (compute) begin
         sel_ff     <= group_wide[1:0];
         states_ff  <= flat_states[misd_pkg::STATES_W-1:0];
         changed_ff <= changed_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, changed_ff, states_ff, sel_ff};

   // The group only moves together with a restart of the tick count
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && group_ff != $past(group_ff)) |-> (sample_cnt_ff == '0))
      else $error("group advanced without clearing the tick count");

   // Back-pressure reaches the input only when both stages are full
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled with a free stage");

   // A processed tick always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      compute |=> out_valid_ff)
      else $error("processed tick lost");

endmodule
